/* src/rau_pkg.sv */
// Package for the rational arithmetic unit: widths, codes and command types.
// No dependencies.
package rau_pkg;

  localparam int DefWordWidth = 32;
  localparam int FieldWidth   = 32;

  localparam logic [1:0] ACT_ADD = 2'd0;
  localparam logic [1:0] ACT_SUB = 2'd1;
  localparam logic [1:0] ACT_MUL = 2'd2;
  localparam logic [1:0] ACT_DIV = 2'd3;

  localparam logic [1:0] ERR_OK       = 2'd0;
  localparam logic [1:0] ERR_ZERO_DEN = 2'd1;
  localparam logic [1:0] ERR_DIV_ZERO = 2'd2;
  localparam logic [1:0] ERR_OVERFLOW = 2'd3;

  // datapath operation selects
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_LOAD   = 3'd1;  // capture operands, magnitudes
  localparam logic [2:0] OP_GSTART = 3'd2;  // start gcd on current pair
  localparam logic [2:0] OP_GSTEP  = 3'd3;  // one division bit / swap step
  localparam logic [2:0] OP_DIVIDE = 3'd4;  // divide num and den by g (bit step)
  localparam logic [2:0] OP_CROSS  = 3'd5;  // form cross products / combine
  localparam logic [2:0] OP_FINISH = 3'd6;  // range check, build result

  typedef struct packed {
    logic [2:0] op;
    logic [1:0] sel;     // which pair: 0 left, 1 right, 2 result
    logic [1:0] phase;   // cross phase
  } rau_cmd_t;

  typedef struct packed {
    logic zero_den;
    logic div_zero;
    logic num_zero;      // selected pair numerator is zero
    logic gcd_done;      // remainder became zero
    logic step_done;     // current long-division finished
  } rau_stat_t;

endpackage

/* src/rau_datapath.sv */
// Datapath of the rational arithmetic unit: operand registers, restoring
// divider shared by Euclid and reduction, multiplier. Depends on rau_pkg.
module rau_datapath #(
  parameter int WordWidth = rau_pkg::DefWordWidth
) (
  input  logic                              clk,
  input  logic                              rst,
  input  rau_pkg::rau_cmd_t                 cmd,
  output rau_pkg::rau_stat_t                stat,
  input  logic [1:0]                        in_action,
  input  logic [rau_pkg::FieldWidth-1:0]    in_ln,
  input  logic [rau_pkg::FieldWidth-1:0]    in_ld,
  input  logic [rau_pkg::FieldWidth-1:0]    in_rn,
  input  logic [rau_pkg::FieldWidth-1:0]    in_rd,
  output logic [rau_pkg::FieldWidth-1:0]    res_num,
  output logic [rau_pkg::FieldWidth-2:0]    res_den,
  output logic [1:0]                        res_err
);
  import rau_pkg::*;

  localparam int DW = 2 * WordWidth + 1;           // double width plus carry
  localparam int CW = $clog2(DW + 1);

  logic [1:0]    action;
  logic          s1, s2, rs;
  logic [DW-1:0] n1, d1, n2, d2, rn, rd;
  // divider: a / b -> quotient in ga, remainder in r
  logic [DW-1:0] ga, gb, r;
  logic [CW-1:0] cnt;
  logic          div_run;
  logic          gmode;  // 1: gcd remainder, 0: reduce by g
  logic          second; // reduce: dividing the denominator
  logic [DW-1:0] t1, t2;

  logic signed [WordWidth-1:0] wln, wld, wrn, wrd;
  logic [DW-1:0] cur_n, cur_d;
  logic [DW-1:0] rtry;
  logic [DW-1:0] lim;
  logic          u2;

  assign wln = in_ln[WordWidth-1:0];
  assign wld = in_ld[WordWidth-1:0];
  assign wrn = in_rn[WordWidth-1:0];
  assign wrd = in_rd[WordWidth-1:0];
  assign lim = {{(DW-WordWidth){1'b0}}, 1'b1, {(WordWidth-1){1'b0}}};

  function automatic logic [DW-1:0] mag(input logic signed [WordWidth-1:0] x);
    logic [DW-1:0] e;
    e = {{(DW-WordWidth){x[WordWidth-1]}}, x};
    mag = x[WordWidth-1] ? (~e + 1'b1) : e;
  endfunction

  // magnitudes up to 2^(WordWidth-1) fit in WordWidth unsigned bits
  function automatic logic [DW-1:0] mulw(input logic [WordWidth-1:0] a,
                                         input logic [WordWidth-1:0] b);
    logic [2*WordWidth-1:0] p;
    p = a * b;
    mulw = {1'b0, p};
  endfunction

  always_comb begin
    case (cmd.sel)
      2'd0:    begin cur_n = n1; cur_d = d1; end
      2'd1:    begin cur_n = n2; cur_d = d2; end
      default: begin cur_n = rn; cur_d = rd; end
    endcase
  end

  assign rtry = {r[DW-2:0], ga[DW-1]};
  assign u2   = (action == ACT_SUB) ? ~s2 : s2;

  assign stat.zero_den  = (d1 == '0) || (d2 == '0);
  assign stat.div_zero  = (action == ACT_DIV) && (n2 == '0);
  assign stat.num_zero  = (cur_n == '0);
  assign stat.gcd_done  = (gb == '0);
  assign stat.step_done = !div_run;

  always_ff @(posedge clk) begin
    if (rst) begin
      div_run <= 1'b0;
      cnt     <= '0;
    end else begin
      case (cmd.op)
        OP_LOAD: begin
          action <= in_action;
          s1 <= wln[WordWidth-1] ^ wld[WordWidth-1];
          s2 <= wrn[WordWidth-1] ^ wrd[WordWidth-1];
          n1 <= mag(wln); d1 <= mag(wld);
          n2 <= mag(wrn); d2 <= mag(wrd);
        end
        OP_GSTART: begin
          if (cur_n == '0) begin
            case (cmd.sel)
              2'd0:    begin s1 <= 1'b0; d1 <= DW'(1); end
              2'd1:    begin s2 <= 1'b0; d2 <= DW'(1); end
              default: begin rs <= 1'b0; rd <= DW'(1); end
            endcase
          end
          ga <= cur_n; gb <= cur_d; gmode <= 1'b1;
          r <= '0; cnt <= CW'(DW); div_run <= 1'b1;
        end
        OP_GSTEP: begin
          // restoring division: ga = dividend shifting into quotient
          if (div_run) begin
            if (rtry >= gb) begin
              r  <= rtry - gb;
              ga <= {ga[DW-2:0], 1'b1};
            end else begin
              r  <= rtry;
              ga <= {ga[DW-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
            if (cnt == CW'(1)) div_run <= 1'b0;
          end else if (gmode && gb != '0) begin
            // ga <- gb, gb <- remainder; restart if nonzero
            ga <= gb; gb <= r; r <= '0;
            if (r != '0) begin
              cnt <= CW'(DW); div_run <= 1'b1;
            end
          end
        end
        OP_DIVIDE: begin
          // gcd sits in ga; start dividing numerator (phase 0) or den (1)
          if (!div_run && cmd.phase == 2'd0) begin
            gmode <= 1'b0; second <= 1'b0;
            gb <= ga; ga <= cur_n; r <= '0; cnt <= CW'(DW); div_run <= 1'b1;
          end else if (div_run) begin
            if (rtry >= gb) begin
              r  <= rtry - gb; ga <= {ga[DW-2:0], 1'b1};
            end else begin
              r  <= rtry; ga <= {ga[DW-2:0], 1'b0};
            end
            cnt <= cnt - 1'b1;
            if (cnt == CW'(1)) div_run <= 1'b0;
          end else if (!second) begin
            case (cmd.sel)
              2'd0:    n1 <= ga;
              2'd1:    n2 <= ga;
              default: rn <= ga;
            endcase
            second <= 1'b1;
            ga <= cur_d; r <= '0; cnt <= CW'(DW); div_run <= 1'b1;
          end else begin
            case (cmd.sel)
              2'd0:    d1 <= ga;
              2'd1:    d2 <= ga;
              default: rd <= ga;
            endcase
          end
        end
        OP_CROSS: begin
          case (cmd.phase)
            2'd0: begin
              t1 <= mulw(n1[WordWidth-1:0], d2[WordWidth-1:0]);
              t2 <= mulw((action == ACT_MUL) ? n1[WordWidth-1:0] : d1[WordWidth-1:0],
                         n2[WordWidth-1:0]);
            end
            2'd1: begin
              rd <= mulw(d1[WordWidth-1:0], d2[WordWidth-1:0]);
            end
            default: begin
              if (action == ACT_MUL) begin
                rn <= t2; rs <= s1 ^ s2;
              end else if (action == ACT_DIV) begin
                rn <= t1; rd <= t2; rs <= s1 ^ s2;
              end else if (((t1 != '0) & s1) == ((t2 != '0) & u2)) begin
                rn <= t1 + t2; rs <= (t1 != '0) & s1;
              end else if (t1 >= t2) begin
                rn <= t1 - t2; rs <= (t1 != '0) & s1;
              end else begin
                rn <= t2 - t1; rs <= (t2 != '0) & u2;
              end
            end
          endcase
        end
        OP_FINISH: begin
          res_num <= '0;
          res_den <= (FieldWidth-1)'(1);
          if (stat.zero_den) res_err <= ERR_ZERO_DEN;
          else if (stat.div_zero) res_err <= ERR_DIV_ZERO;
          else if (rd >= lim || (rs ? rn > lim : rn >= lim)) res_err <= ERR_OVERFLOW;
          else begin
            res_err <= ERR_OK;
            res_num <= FieldWidth'($signed(rs ? -rn[WordWidth-1:0] : rn[WordWidth-1:0]));
            res_den <= (FieldWidth-1)'(rd[WordWidth-1:0]);
          end
        end
        default: ;
      endcase
    end
  end

  // divider never runs past its bit count
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    div_run |-> cnt != '0) else $error("divider count underflow");
  a_stop: assert property (@(posedge clk) disable iff (rst)
    (div_run && cnt == CW'(1) && (cmd.op == OP_GSTEP || cmd.op == OP_DIVIDE))
      |=> !div_run) else $error("divider did not stop");
  a_res_den: assert property (@(posedge clk) disable iff (rst)
    $past(cmd.op == OP_FINISH) |-> res_den != '0) else $error("zero result den");
endmodule

/* src/rau_control.sv */
// Sequencer of the rational arithmetic unit: handshake and command stream
// to the datapath. Depends on rau_pkg.
module rau_control (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_fire,
  output logic               busy,
  output logic               done,
  input  logic               out_taken,
  output rau_pkg::rau_cmd_t  cmd,
  input  rau_pkg::rau_stat_t stat
);
  import rau_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_GST   = 4'd2;
  localparam logic [3:0] S_GRUN  = 4'd3;
  localparam logic [3:0] S_DIV0  = 4'd4;
  localparam logic [3:0] S_DRUN  = 4'd5;
  localparam logic [3:0] S_CR0   = 4'd6;
  localparam logic [3:0] S_CR1   = 4'd7;
  localparam logic [3:0] S_CR2   = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_OUT   = 4'd10;

  logic [3:0] state, state_next;
  logic [1:0] sel, sel_next;
  logic [1:0] dcnt, dcnt_next;  // reduce sub-steps: num, den

  always_comb begin
    state_next = state; sel_next = sel; dcnt_next = dcnt;
    cmd = '{op: OP_NONE, sel: sel, phase: 2'd0};
    case (state)
      S_IDLE: if (in_fire) begin
        cmd.op = OP_LOAD; state_next = S_CHECK; sel_next = 2'd0;
      end
      S_CHECK: state_next = (stat.zero_den) ? S_FIN : S_GST;
      S_GST: begin
        cmd.op = OP_GSTART;
        state_next = stat.num_zero ? S_GST : S_GRUN;
        if (stat.num_zero) begin
          // zero numerator: denominator forced to one, skip gcd
          if (sel == 2'd0) sel_next = 2'd1;
          else if (sel == 2'd1) state_next = stat.div_zero ? S_FIN : S_CR0;
          else state_next = S_FIN;
        end
      end
      S_GRUN: begin
        cmd.op = OP_GSTEP;
        if (stat.step_done && stat.gcd_done) begin
          state_next = S_DIV0; dcnt_next = 2'd0;
        end
      end
      S_DIV0: begin
        cmd.op = OP_DIVIDE; cmd.phase = 2'd0; state_next = S_DRUN; dcnt_next = 2'd0;
      end
      S_DRUN: begin
        cmd.op = OP_DIVIDE; cmd.phase = 2'd1;
        if (stat.step_done) begin
          dcnt_next = dcnt + 2'd1;
          if (dcnt == 2'd1) begin
            if (sel == 2'd0) begin sel_next = 2'd1; state_next = S_GST; end
            else if (sel == 2'd1) state_next = stat.div_zero ? S_FIN : S_CR0;
            else state_next = S_FIN;
          end
        end
      end
      S_CR0: begin cmd.op = OP_CROSS; cmd.phase = 2'd0; state_next = S_CR1; end
      S_CR1: begin cmd.op = OP_CROSS; cmd.phase = 2'd1; state_next = S_CR2; end
      S_CR2: begin
        cmd.op = OP_CROSS; cmd.phase = 2'd2; sel_next = 2'd2; state_next = S_GST;
      end
      S_FIN: begin cmd.op = OP_FINISH; state_next = S_OUT; end
      S_OUT: if (out_taken) state_next = S_IDLE;
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE; sel <= 2'd0; dcnt <= 2'd0;
    end else begin
      state <= state_next; sel <= sel_next; dcnt <= dcnt_next;
    end
  end

  assign busy = (state != S_IDLE);
  assign done = (state == S_OUT);

  a_out: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && !out_taken) |=> state == S_OUT) else $error("result dropped");
  a_load: assert property (@(posedge clk) disable iff (rst)
    (cmd.op == OP_LOAD) |-> state == S_IDLE) else $error("load while busy");
  a_fin: assert property (@(posedge clk) disable iff (rst)
    (state == S_FIN) |=> state == S_OUT) else $error("finish not followed by output");
endmodule

/* src/rational_arithmetic_unit.sv */
// Rational arithmetic unit, one item at a time. Every Euclid remainder step
// and every divide-out of the gcd runs a bit-serial restoring divider of
// 2*WORD_WIDTH+1 bits; the divider is shared by both operand reductions and
// the result reduction, and each reduction costs its Euclid steps plus two
// more divisions. A zero numerator skips the Euclid chain for its pair, and
// a zero denominator sends the item straight to the finish step. The result
// word stays on the master side until taken; a new word is accepted after.
// Depends on rau_pkg, rau_control, rau_datapath.
module rational_arithmetic_unit #(
  parameter int WORD_WIDTH = rau_pkg::DefWordWidth
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  // action[1:0], left_numerator[33:2], left_denominator[65:34],
  // right_numerator[97:66], right_denominator[129:98], zero pad to 136
  input  logic [135:0] s_tdata,
  output logic         m_tvalid,
  input  logic         m_tready,
  // result_numerator[31:0], result_denominator[62:32], error_code[64:63], pad
  output logic [71:0]  m_tdata
);
  import rau_pkg::*;

  rau_cmd_t  cmd;
  rau_stat_t stat;
  logic      busy, done;
  logic [FieldWidth-1:0] rnum;
  logic [FieldWidth-2:0] rden;
  logic [1:0]            rerr;

  assign s_tready = !busy;
  assign m_tvalid = done;
  assign m_tdata  = {7'd0, rerr, rden, rnum};

  rau_control u_ctl (
    .clk(clk), .rst(rst), .in_fire(s_tvalid && s_tready), .busy(busy),
    .done(done), .out_taken(m_tready), .cmd(cmd), .stat(stat)
  );

  rau_datapath #(.WordWidth(WORD_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .stat(stat),
    .in_action(s_tdata[1:0]), .in_ln(s_tdata[33:2]), .in_ld(s_tdata[65:34]),
    .in_rn(s_tdata[97:66]), .in_rd(s_tdata[129:98]),
    .res_num(rnum), .res_den(rden), .res_err(rerr)
  );
endmodule
